### rtl/core/vdpd_pkg.sv
package vdpd_pkg;

  // varint group layout
  localparam int unsigned GroupBits = 7;
  localparam int unsigned MaxGroups = 5;
  localparam int unsigned IdWidth   = 32;
  localparam int unsigned CntWidth  = 3;
  localparam int unsigned ShWidth   = 5;

  typedef logic [CntWidth-1:0] grp_cnt_t;
  typedef logic [IdWidth-1:0]  file_id_t;
  typedef logic [7:0]          data_byte_t;

  // input register contents handed to the decode step
  typedef struct packed {
    logic       valid;
    data_byte_t data_byte;
    logic       last_in_run;
  } stage_t;

  // bit offset of a group inside the partial value
  function automatic logic [ShWidth-1:0] group_shift(grp_cnt_t cnt);
    logic [ShWidth-1:0] sh;
    sh = ShWidth'(cnt) * ShWidth'(GroupBits);
    return sh;
  endfunction

endpackage

### rtl/core/vdpd_if.sv
interface vdpd_in_if;
  logic                valid;
  logic                ready;
  vdpd_pkg::data_byte_t data_byte;
  logic                last_in_run;

  modport source (output valid, output data_byte, output last_in_run, input ready);
  modport sink   (input valid, input data_byte, input last_in_run, output ready);
endinterface

interface vdpd_out_if;
  logic              valid;
  logic              ready;
  vdpd_pkg::file_id_t file_id;
  logic              overlong;

  modport source (output valid, output file_id, output overlong, input ready);
  modport sink   (input valid, input file_id, input overlong, output ready);
endinterface

### rtl/core/vdpd_in_reg.sv
module vdpd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  vdpd_in_if.sink          in_i,
  input  logic             take_i,
  output vdpd_pkg::stage_t stage_o
);
  import vdpd_pkg::*;

  logic       valid_q;
  data_byte_t data_q;
  logic       last_q;

  // register frees up when empty or when the decode step takes it
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_in_run;
    end
  end

  assign stage_o.valid       = valid_q;
  assign stage_o.data_byte   = data_q;
  assign stage_o.last_in_run = last_q;

endmodule

### rtl/core/vdpd_step.sv
module vdpd_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vdpd_pkg::stage_t stage_i,
  output logic             take_o,
  vdpd_out_if.source       out_o
);
  import vdpd_pkg::*;

  // decode state; the base is kept minus one so a single add gives the id
  file_id_t partial_q;
  grp_cnt_t cnt_q;
  logic     ovl_q;
  file_id_t base_m1_q;

  logic     out_valid_q;
  file_id_t out_id_q;
  logic     out_ovl_q;

  logic     ends;
  logic     out_free;
  logic     in_range;
  file_id_t shifted;
  file_id_t partial_nxt;
  logic     ovl_nxt;
  file_id_t sum;

  assign ends     = !stage_i.data_byte[7];
  assign out_free = !out_valid_q || out_o.ready;
  assign take_o   = stage_i.valid && (!ends || out_free);

  // groups do not overlap, so or-ing is the same as adding
  assign in_range    = cnt_q < CntWidth'(MaxGroups);
  assign shifted     = IdWidth'(stage_i.data_byte[GroupBits-1:0]) << group_shift(cnt_q);
  assign partial_nxt = in_range ? (partial_q | shifted) : partial_q;
  assign ovl_nxt     = ovl_q | !in_range;
  assign sum         = base_m1_q + partial_nxt;

  // state update per taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      cnt_q     <= '0;
      ovl_q     <= 1'b0;
      base_m1_q <= '1;
    end else if (take_o) begin
      if (ends || stage_i.last_in_run) begin
        partial_q <= '0;
        cnt_q     <= '0;
        ovl_q     <= 1'b0;
      end else begin
        partial_q <= partial_nxt;
        cnt_q     <= cnt_q + CntWidth'(in_range);
        ovl_q     <= ovl_nxt;
      end
      if (stage_i.last_in_run) begin
        base_m1_q <= '1;
      end else if (ends) begin
        base_m1_q <= sum;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && ends) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o && ends) begin
      out_id_q  <= sum;
      out_ovl_q <= ovl_nxt;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.file_id  = out_id_q;
  assign out_o.overlong = out_ovl_q;

endmodule

### rtl/core/varint_delta_posting_decoder_top.sv
// posting-list varint decoder with delta accumulation
// in_i carries one compressed byte per transaction (data_byte, last_in_run);
// bit 7 set marks a continuation byte, groups arrive least significant first.
// out_o carries one transaction per finished code: file_id is the
// running sum of the run's codes minus one, modulo 2^32, and overlong flags a
// code of more than five groups (extra groups are ignored).
// last_in_run clears the running sum and any unfinished code after its byte.
// an accepted byte sits in the input register, and its result is loaded from
// there into the result register, which offers it at the output.
// throughput: one byte per cycle unless a byte ending a code waits behind
// a held result; the shift-or of a group plus one 32-bit add of the running
// sum sit between the two registers.
// reset clears the valid flags of the input and result registers and all
// decode state; no transaction is lost or repeated.
// when the receiver stalls, the pending result is held, the input register
// still takes bytes that finish no code, and in_i.ready drops once a byte
// that ends a code waits behind the held result.
module varint_delta_posting_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdpd_in_if.sink     in_i,
  vdpd_out_if.source  out_o
);
  import vdpd_pkg::*;

  stage_t stage;
  logic   take;

  vdpd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .stage_o (stage)
  );

  vdpd_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule
